[src/assert_macros.svh]
// assertion macros shared by the checker files
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/hpd_pkg.sv]
// shared types and codes for the ham6 planar pixel decoder
// no dependencies
package hpd_pkg;

  localparam int COLOUR_W   = 12;
  localparam int PAL_IDX_W  = 4;
  localparam int PAL_DEPTH  = 16;
  localparam int COUNT_W    = 13;
  localparam int MAP_ADDR_W = 12;
  localparam int PIX_CNT_W  = 3;
  localparam int PLANES     = 6;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] CTRL_PAL   = 2'd0;
  localparam logic [1:0] CTRL_BLUE  = 2'd1;
  localparam logic [1:0] CTRL_RED   = 2'd2;
  localparam logic [1:0] CTRL_GREEN = 2'd3;

  localparam logic [PIX_CNT_W-1:0] LAST_PIX = 3'd7;

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    colour_t colour;
    logic    last;
  } pixel_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } seq_stat_t;

endpackage

[src/hpd_seq.sv]
// pixel sequencer: palette, held colour and the hold-and-modify step
// one pixel per cycle while pix_ready is high, msb first; depends on hpd_pkg
module hpd_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        dec_start,
  input  logic                        row_start,
  input  logic [7:0]                  plane_byte [hpd_pkg::PLANES],
  input  logic                        load_we,
  input  logic [hpd_pkg::PAL_IDX_W-1:0] load_idx,
  input  hpd_pkg::colour_t            load_val,
  output logic                        pix_valid,
  input  logic                        pix_ready,
  output hpd_pkg::pixel_t             pix,
  output hpd_pkg::seq_stat_t          stat
);
  import hpd_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [PIX_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]           pl_r [PLANES];
  colour_t              held_r, held_nxt;
  colour_t              pal_r [PAL_DEPTH];
  colour_t              pal0_r;
  logic [3:0]           data;
  logic [1:0]           ctrl;
  colour_t              colour;
  logic                 emit;

  assign data = {pl_r[3][7], pl_r[2][7], pl_r[1][7], pl_r[0][7]};
  assign ctrl = {pl_r[5][7], pl_r[4][7]};
  assign emit = busy_r && pix_ready;

  always_comb begin
    unique case (ctrl)
      CTRL_PAL:   colour = pal_r[data];
      CTRL_BLUE:  colour = {held_r[11:4], data};
      CTRL_RED:   colour = {data, held_r[7:0]};
      CTRL_GREEN: colour = {held_r[11:8], data, held_r[3:0]};
      default:    colour = held_r;
    endcase
  end

  assign pix_valid   = busy_r;
  assign pix.colour  = colour;
  assign pix.last    = (cnt_r == LAST_PIX);
  assign stat.busy   = busy_r;
  assign stat.finish = emit && (cnt_r == LAST_PIX);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    if (emit) begin
      held_nxt = colour;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == LAST_PIX) begin
        busy_nxt = 1'b0;
      end
    end
    if (dec_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      if (row_start) begin
        held_nxt = pal0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      held_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

  // plane shift registers
  always_ff @(posedge clk) begin
    for (int p = 0; p < PLANES; p++) begin
      if (dec_start) begin
        pl_r[p] <= plane_byte[p];
      end else if (emit) begin
        pl_r[p] <= {pl_r[p][6:0], 1'b0};
      end
    end
  end

  // palette, entry 0 mirrored for row reload
  always_ff @(posedge clk) begin
    if (load_we) begin
      pal_r[load_idx] <= load_val;
      if (load_idx == '0) begin
        pal0_r <= load_val;
      end
    end
  end

endmodule

[src/hpd_cmap.sv]
// used-colour map: 4096 x 1 memory with read-modify-write, distinct count
// and the output register; depends on hpd_pkg
module hpd_cmap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  hpd_pkg::pixel_t             pix,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hpd_pkg::colour_t            out_pixel_rgb,
  output logic                        out_first_use,
  output logic [hpd_pkg::COUNT_W-1:0] out_distinct_count,
  output logic                        out_last
);
  import hpd_pkg::*;

  logic                  map_mem [2**MAP_ADDR_W];
  logic                  rd_r;
  logic                  hit_r, hit_nxt;
  logic [MAP_ADDR_W:0]   clr_r;
  logic                  lk_valid_r, lk_valid_nxt;
  colour_t               lk_colour_r;
  logic                  lk_last_r;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  lk_adv, lk_load, first;
  logic                  wr_en, wr_data;
  logic [MAP_ADDR_W-1:0] raddr, waddr;

  assign clearing  = !clr_r[MAP_ADDR_W];
  assign lk_adv    = lk_valid_r && (!out_valid_r || out_ready);
  assign pix_ready = !clearing && (!lk_valid_r || lk_adv);
  assign lk_load   = pix_valid && pix_ready;
  assign raddr     = lk_load ? pix.colour : lk_colour_r;
  assign first     = !(rd_r || hit_r);

  assign wr_en   = clearing || (lk_adv && first);
  assign wr_data = !clearing;
  assign waddr   = clearing ? clr_r[MAP_ADDR_W-1:0] : lk_colour_r;
  // read issued in the same cycle as a write to that entry sees old data
  assign hit_nxt = !clearing && lk_adv && first && (lk_colour_r == raddr);

  assign count_nxt     = count_r + {{(COUNT_W-1){1'b0}}, first};
  assign lk_valid_nxt  = lk_load ? 1'b1 : (lk_adv ? 1'b0 : lk_valid_r);
  assign out_valid_nxt = lk_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[waddr] <= wr_data;
    end
    rd_r <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      hit_r       <= 1'b0;
      lk_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end
      hit_r       <= hit_nxt;
      lk_valid_r  <= lk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (lk_adv) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lk_load) begin
      lk_colour_r <= pix.colour;
      lk_last_r   <= pix.last;
    end
    if (lk_adv) begin
      out_pixel_rgb      <= lk_colour_r;
      out_first_use      <= first;
      out_distinct_count <= count_nxt;
      out_last           <= lk_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/ham6_planar_pixel_decoder.sv]
// top level of the ham6 planar pixel decoder
// depends on hpd_pkg, hpd_seq, hpd_cmap
//
// A load beat writes one of 16 palette entries and gives no result; a decode
// beat gives eight pixel beats, one per cycle unless out_ready stalls them, and the
// next item is taken in the cycle its last pixel leaves the sequencer. The
// rate is set by the held-colour step (one pixel per cycle) and the single
// write port of the 4096-entry used-colour memory, read in the lookup stage
// ahead of its write with forwarding between back-to-back pixels. After
// reset the block clears every entry of that memory before in_ready rises.
// The first pixel beat passes the plane, lookup and output registers.
module ham6_planar_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [hpd_pkg::PAL_IDX_W-1:0] in_pal_index,
  input  logic [hpd_pkg::COLOUR_W-1:0]  in_pal_value,
  input  logic [7:0]                    in_plane0_byte,
  input  logic [7:0]                    in_plane1_byte,
  input  logic [7:0]                    in_plane2_byte,
  input  logic [7:0]                    in_plane3_byte,
  input  logic [7:0]                    in_plane4_byte,
  input  logic [7:0]                    in_plane5_byte,
  input  logic                          in_row_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hpd_pkg::COLOUR_W-1:0]  out_pixel_rgb,
  output logic                          out_first_use,
  output logic [hpd_pkg::COUNT_W-1:0]   out_distinct_count,
  output logic                          out_last
);
  import hpd_pkg::*;

  logic      in_beat, load_we, dec_start;
  logic      pix_valid, pix_ready, clearing;
  pixel_t    pix;
  seq_stat_t stat;
  logic [7:0] plane_byte [PLANES];

  assign plane_byte[0] = in_plane0_byte;
  assign plane_byte[1] = in_plane1_byte;
  assign plane_byte[2] = in_plane2_byte;
  assign plane_byte[3] = in_plane3_byte;
  assign plane_byte[4] = in_plane4_byte;
  assign plane_byte[5] = in_plane5_byte;

  assign in_ready  = !clearing && (!stat.busy || stat.finish);
  assign in_beat   = in_valid && in_ready;
  assign load_we   = in_beat && (in_op == OP_LOAD);
  assign dec_start = in_beat && (in_op == OP_DECODE);

  hpd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_start (dec_start),
    .row_start (in_row_start),
    .plane_byte(plane_byte),
    .load_we   (load_we),
    .load_idx  (in_pal_index),
    .load_val  (in_pal_value),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .stat      (stat)
  );

  hpd_cmap u_cmap (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix               (pix),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_rgb     (out_pixel_rgb),
    .out_first_use     (out_first_use),
    .out_distinct_count(out_distinct_count),
    .out_last          (out_last)
  );

endmodule

[src/hpd_chk.sv]
// port-level checker for the ham6 planar pixel decoder, bound to the top
// depends on hpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module hpd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hpd_pkg::COLOUR_W-1:0]  out_pixel_rgb,
  input logic                          out_first_use,
  input logic [hpd_pkg::COUNT_W-1:0]   out_distinct_count,
  input logic                          out_last
);
  import hpd_pkg::*;

  logic                         out_beat;
  logic                         out_stall;
  logic [COLOUR_W+COUNT_W+1:0]  out_word;
  logic [COUNT_W-1:0]           cnt_r;
  logic [PIX_CNT_W-1:0]         pos_r;

  assign out_beat  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_pixel_rgb, out_first_use, out_distinct_count, out_last};

  // last delivered count and pixel position within the group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (out_beat) begin
      cnt_r <= out_distinct_count;
      pos_r <= pos_r + 1'b1;
    end
  end

  `ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_word))
  `ASSERT_IMP(a_cnt_new, out_beat && out_first_use, out_distinct_count == cnt_r + 1'b1)
  `ASSERT_IMP(a_cnt_old, out_beat && !out_first_use, out_distinct_count == cnt_r)
  `ASSERT_IMP(a_last_pos, out_beat, out_last == (pos_r == LAST_PIX))

endmodule

bind ham6_planar_pixel_decoder hpd_chk u_hpd_chk (.*);
